// ----- rtl/hdt_pkg.sv -----
// Shared types, widths, register codes and reset values for the Helmert datum transform.
// No dependencies; compiled first.
`default_nettype none

package hdt_pkg;

	// Field widths
	localparam int CW    = 36;  // coordinate
	localparam int OFW   = 24;  // offset register
	localparam int RTW   = 32;  // angle and scale registers
	localparam int KW    = 33;  // signed coefficient, room for a negated minimum
	localparam int DW    = 25;  // signed offset, room for a negated minimum
	localparam int CIW   = 3;   // configuration index
	localparam int CDW   = 32;  // configuration data
	localparam int PSPLIT = 18; // low half of a coordinate in the rotation products
	localparam int CK    = 26;  // chunk width of u in the scale products

	localparam int FRAC_BITS_DEF = 40;

	// Configuration register indexes
	localparam logic [CIW-1:0] REG_OFFSET_X    = 3'd0;
	localparam logic [CIW-1:0] REG_OFFSET_Y    = 3'd1;
	localparam logic [CIW-1:0] REG_OFFSET_Z    = 3'd2;
	localparam logic [CIW-1:0] REG_ROT_X       = 3'd3;
	localparam logic [CIW-1:0] REG_ROT_Y       = 3'd4;
	localparam logic [CIW-1:0] REG_ROT_Z       = 3'd5;
	localparam logic [CIW-1:0] REG_SCALE_DELTA = 3'd6;
	localparam logic [CIW-1:0] REG_DIRECTION   = 3'd7;

	// Reset values of the registers
	localparam logic signed [OFW-1:0] OFFSET_X_RST = -24'sd1100;
	localparam logic signed [OFW-1:0] OFFSET_Y_RST = -24'sd300;
	localparam logic signed [OFW-1:0] OFFSET_Z_RST = -24'sd900;
	localparam logic signed [RTW-1:0] ROT_X_RST    = 32'sd0;
	localparam logic signed [RTW-1:0] ROT_Y_RST    = 32'sd0;
	localparam logic signed [RTW-1:0] ROT_Z_RST    = -32'sd901600;
	localparam logic signed [RTW-1:0] SCALE_RST    = 32'sd131941;
	localparam logic                  DIR_FORWARD  = 1'b0;
	localparam logic                  DIR_REVERSE  = 1'b1;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [KW-1:0] coef_t;
	typedef logic signed [DW-1:0] offs_t;

	// Effective transform, with the direction already folded in
	typedef struct packed {
		coef_t [2:0] c1;  // first row coefficient per axis
		coef_t [2:0] c2;  // second row coefficient per axis
		coef_t       m;   // scale difference
		offs_t [2:0] d;   // translation per axis
	} xform_t;

	// Width of u = S*p + c1*p1 + c2*p2
	function automatic int u_width(input int frac);
		return ((CW + frac > KW + CW) ? CW + frac : KW + CW) + 2;
	endfunction

	// Width of the rounded scale term t = round(m*u / S)
	function automatic int t_width(input int frac);
		return KW + u_width(frac) + 1 - frac;
	endfunction

	// Width of the rounded result before the offset
	function automatic int r_width(input int frac);
		return ((u_width(frac) > t_width(frac)) ? u_width(frac) : t_width(frac)) + 2 - frac;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/hdt_if.sv -----
// Request channels of the Helmert datum transform: point in, result out, register writes.
// Depends on hdt_pkg.
`default_nettype none

interface hdt_point_if;
	import hdt_pkg::*;
	logic   valid;
	logic   ready;
	coord_t in_x;
	coord_t in_y;
	coord_t in_z;
	modport source (output valid, in_x, in_y, in_z, input ready);
	modport sink   (input valid, in_x, in_y, in_z, output ready);
endinterface

interface hdt_result_if;
	import hdt_pkg::*;
	logic   valid;
	logic   ready;
	coord_t out_x;
	coord_t out_y;
	coord_t out_z;
	logic   overflow;
	modport source (output valid, out_x, out_y, out_z, overflow, input ready);
	modport sink   (input valid, out_x, out_y, out_z, overflow, output ready);
endinterface

interface hdt_cfg_if;
	import hdt_pkg::*;
	logic           valid;
	logic           ready;
	logic [CIW-1:0] index;
	logic [CDW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/hdt_rot.sv -----
// Rotation stages s1..s2: split rotation products, then u = S*p + c1*p1 + c2*p2 per axis.
// Depends on hdt_pkg.
`default_nettype none

module hdt_rot #(
	parameter int FRAC_BITS = hdt_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hdt_pkg::coord_t      in_p [3],
	input  hdt_pkg::xform_t      xf,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [hdt_pkg::u_width(FRAC_BITS)-1:0] out_u [3]
);
	import hdt_pkg::*;

	localparam int UW  = u_width(FRAC_BITS);
	localparam int PRW = KW + PSPLIT + 1;

	logic   v_s1, v_s2;
	logic   adv_s1, adv_s2;
	coord_t p1 [3];
	coord_t p2 [3];
	coord_t own_s1 [3];
	logic signed [PRW-1:0] lo1_s1 [3];
	logic signed [PRW-1:0] hi1_s1 [3];
	logic signed [PRW-1:0] lo2_s1 [3];
	logic signed [PRW-1:0] hi2_s1 [3];
	logic signed [UW-1:0]  u_s2 [3];

	// A stage takes a new request when empty or when its contents move on
	assign adv_s2   = !v_s2 || out_ready;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	// Row operands per axis: x uses (y, z), y uses (x, z), z uses (x, y)
	always_comb begin
		p1[0] = in_p[1];
		p2[0] = in_p[2];
		p1[1] = in_p[0];
		p2[1] = in_p[2];
		p1[2] = in_p[0];
		p2[2] = in_p[1];
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	// s1: coefficient times low and high halves of each row operand
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			for (int a = 0; a < 3; a++) begin
				own_s1[a] <= in_p[a];
				lo1_s1[a] <= $signed(xf.c1[a]) * $signed({1'b0, p1[a][PSPLIT-1:0]});
				hi1_s1[a] <= $signed(xf.c1[a]) * $signed(p1[a][CW-1:PSPLIT]);
				lo2_s1[a] <= $signed(xf.c2[a]) * $signed({1'b0, p2[a][PSPLIT-1:0]});
				hi2_s1[a] <= $signed(xf.c2[a]) * $signed(p2[a][CW-1:PSPLIT]);
			end
		end
	end

	// s2: exact sum in units of 1/S mm
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			for (int a = 0; a < 3; a++) begin
				u_s2[a] <= (UW'(own_s1[a]) <<< FRAC_BITS)
					+ (UW'(hi1_s1[a]) <<< PSPLIT) + UW'(lo1_s1[a])
					+ (UW'(hi2_s1[a]) <<< PSPLIT) + UW'(lo2_s1[a]);
			end
		end
	end

	assign out_valid = v_s2;
	assign out_u     = u_s2;

endmodule

`default_nettype wire

// ----- rtl/hdt_scl.sv -----
// Scale stages s3..s5: m*u in chunks, round to t, then round (u + t) down to millimetres.
// Depends on hdt_pkg.
`default_nettype none

module hdt_scl #(
	parameter int FRAC_BITS = hdt_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic signed [hdt_pkg::u_width(FRAC_BITS)-1:0] in_u [3],
	input  hdt_pkg::xform_t xf,
	output logic            out_valid,
	input  logic            out_ready,
	output logic signed [hdt_pkg::r_width(FRAC_BITS)-1:0] out_r [3]
);
	import hdt_pkg::*;

	localparam int UW  = u_width(FRAC_BITS);
	localparam int MW  = KW + UW;
	localparam int TW  = t_width(FRAC_BITS);
	localparam int RW  = r_width(FRAC_BITS);
	localparam int SW  = RW + FRAC_BITS;
	localparam int NCH = (UW + CK - 1) / CK;
	localparam int UXW = NCH * CK;
	localparam int PPW = KW + CK + 1;

	localparam logic [MW:0]   HALF_M = {{(MW + 1 - FRAC_BITS){1'b0}}, 1'b1,
		{(FRAC_BITS - 1){1'b0}}};
	localparam logic [SW-1:0] HALF_S = {{(SW - FRAC_BITS){1'b0}}, 1'b1,
		{(FRAC_BITS - 1){1'b0}}};

	logic v_s3, v_s4, v_s5;
	logic adv_s3, adv_s4, adv_s5;
	logic signed [UXW-1:0] ux [3];
	logic signed [PPW-1:0] pp [3][NCH];
	logic signed [PPW-1:0] pp_s3 [3][NCH];
	logic signed [UW-1:0]  u_s3 [3];
	logic signed [MW:0]    acc [3];
	logic signed [TW-1:0]  t_s4 [3];
	logic signed [UW-1:0]  u_s4 [3];
	logic signed [SW-1:0]  sum [3];
	logic signed [RW-1:0]  r_s5 [3];

	assign adv_s5   = !v_s5 || out_ready;
	assign adv_s4   = !v_s4 || adv_s5;
	assign adv_s3   = !v_s3 || adv_s4;
	assign in_ready = adv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv_s3) v_s3 <= in_valid;
			if (adv_s4) v_s4 <= v_s3;
			if (adv_s5) v_s5 <= v_s4;
		end
	end

	// Chunk products: lower chunks unsigned, top chunk carries the sign
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			ux[a] = UXW'(in_u[a]);
			for (int j = 0; j < NCH; j++) begin
				if (j == NCH - 1) begin
					pp[a][j] = $signed(ux[a][j*CK +: CK]) * $signed(xf.m);
				end else begin
					pp[a][j] = $signed({1'b0, ux[a][j*CK +: CK]}) * $signed(xf.m);
				end
			end
		end
	end

	// s3
	always_ff @(posedge clk) begin
		if (adv_s3) begin
			u_s3  <= in_u;
			pp_s3 <= pp;
		end
	end

	// Recombine m*u and round half up to units of 1/S mm
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			acc[a] = $signed(HALF_M);
			for (int j = 0; j < NCH; j++) begin
				acc[a] = acc[a] + ((MW + 1)'(pp_s3[a][j]) <<< (j * CK));
			end
		end
	end

	// s4
	always_ff @(posedge clk) begin
		if (adv_s4) begin
			for (int a = 0; a < 3; a++) begin
				t_s4[a] <= TW'(acc[a] >>> FRAC_BITS);
				u_s4[a] <= u_s3[a];
			end
		end
	end

	// q = u + t, then round half up to millimetres
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sum[a] = SW'(u_s4[a]) + SW'(t_s4[a]) + $signed(HALF_S);
		end
	end

	// s5
	always_ff @(posedge clk) begin
		if (adv_s5) begin
			for (int a = 0; a < 3; a++) begin
				r_s5[a] <= RW'(sum[a] >>> FRAC_BITS);
			end
		end
	end

	assign out_valid = v_s5;
	assign out_r     = r_s5;

endmodule

`default_nettype wire

// ----- rtl/hdt_sat.sv -----
// Output stage s6: add the translation, clamp to the coordinate range, flag overflow.
// Depends on hdt_pkg.
`default_nettype none

module hdt_sat #(
	parameter int FRAC_BITS = hdt_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic signed [hdt_pkg::r_width(FRAC_BITS)-1:0] in_r [3],
	input  hdt_pkg::xform_t xf,
	output logic            out_valid,
	input  logic            out_ready,
	output hdt_pkg::coord_t out_c [3],
	output logic            out_ovf
);
	import hdt_pkg::*;

	localparam int RW = r_width(FRAC_BITS);

	localparam logic signed [RW:0] C_HI = $signed({{(RW + 2 - CW){1'b0}}, {(CW - 1){1'b1}}});
	localparam logic signed [RW:0] C_LO = $signed({{(RW + 2 - CW){1'b1}}, {(CW - 1){1'b0}}});

	logic              v_s6;
	logic              adv_s6;
	logic signed [RW:0] e [3];
	coord_t            c [3];
	logic [2:0]        clip;
	coord_t            c_s6 [3];
	logic              ovf_s6;

	assign adv_s6   = !v_s6 || out_ready;
	assign in_ready = adv_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv_s6) begin
			v_s6 <= in_valid;
		end
	end

	// Offset and clamp per axis
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			e[a] = (RW + 1)'(in_r[a]) + (RW + 1)'(xf.d[a]);
			if (e[a] > C_HI) begin
				c[a]    = CW'(C_HI);
				clip[a] = 1'b1;
			end else if (e[a] < C_LO) begin
				c[a]    = CW'(C_LO);
				clip[a] = 1'b1;
			end else begin
				c[a]    = CW'(e[a]);
				clip[a] = 1'b0;
			end
		end
	end

	// s6, the output register
	always_ff @(posedge clk) begin
		if (adv_s6) begin
			c_s6   <= c;
			ovf_s6 <= |clip;
		end
	end

	assign out_valid = v_s6;
	assign out_c     = c_s6;
	assign out_ovf   = ovf_s6;

endmodule

`default_nettype wire

// ----- rtl/helmert_datum_transform.sv -----
// Top level of the seven-parameter Helmert datum transform: registers and the s1..s6 pipeline.
// Depends on hdt_pkg, hdt_if, hdt_rot, hdt_scl and hdt_sat.
//
//   channel  | role | accepted when      | carries
//   ---------+------+--------------------+---------------------------------
//   point    | in   | valid && ready     | in_x, in_y, in_z
//   result   | out  | valid && ready     | out_x, out_y, out_z, overflow
//   cfg      | in   | valid (ready tied) | index, data
//
// One point per cycle while results are taken; each request passes through six register stages,
// one each for the rotation products, the rotation sum, the scale
// chunk products, the scale rounding, the final rounding and the clamp/output.
// Reset clears every valid bit and loads the register defaults.
// Ready runs back combinationally: a stage takes a request whenever it is empty or its
// contents move on, so bubbles close up and the input stalls only once all six are full.
`default_nettype none

module helmert_datum_transform #(
	parameter int FRAC_BITS = hdt_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	hdt_point_if.sink           point,
	hdt_result_if.source        result,
	hdt_cfg_if.sink             cfg
);
	import hdt_pkg::*;

	localparam int UW = u_width(FRAC_BITS);
	localparam int RW = r_width(FRAC_BITS);

	logic signed [OFW-1:0] off_q [3];
	logic signed [RTW-1:0] rot_q [3];
	logic signed [RTW-1:0] scale_q;
	logic                  dir_q;

	coef_t  rx, ry, rz, ms;
	xform_t xf;
	coord_t pt [3];
	logic   rot_v, rot_r;
	logic   scl_v, scl_r;
	logic signed [UW-1:0] u [3];
	logic signed [RW-1:0] r [3];
	coord_t res_c [3];

	// Register writes, truncated to each register's width
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q[0] <= OFFSET_X_RST;
			off_q[1] <= OFFSET_Y_RST;
			off_q[2] <= OFFSET_Z_RST;
			rot_q[0] <= ROT_X_RST;
			rot_q[1] <= ROT_Y_RST;
			rot_q[2] <= ROT_Z_RST;
			scale_q  <= SCALE_RST;
			dir_q    <= DIR_FORWARD;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_OFFSET_X:    off_q[0] <= cfg.data[OFW-1:0];
				REG_OFFSET_Y:    off_q[1] <= cfg.data[OFW-1:0];
				REG_OFFSET_Z:    off_q[2] <= cfg.data[OFW-1:0];
				REG_ROT_X:       rot_q[0] <= cfg.data[RTW-1:0];
				REG_ROT_Y:       rot_q[1] <= cfg.data[RTW-1:0];
				REG_ROT_Z:       rot_q[2] <= cfg.data[RTW-1:0];
				REG_SCALE_DELTA: scale_q  <= cfg.data[RTW-1:0];
				REG_DIRECTION:   dir_q    <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Effective coefficients; reverse negates angles, scale and offsets
	always_comb begin
		rx = (dir_q == DIR_REVERSE) ? -KW'(rot_q[0]) : KW'(rot_q[0]);
		ry = (dir_q == DIR_REVERSE) ? -KW'(rot_q[1]) : KW'(rot_q[1]);
		rz = (dir_q == DIR_REVERSE) ? -KW'(rot_q[2]) : KW'(rot_q[2]);
		ms = (dir_q == DIR_REVERSE) ? -KW'(scale_q) : KW'(scale_q);
		xf.c1[0] = rz;
		xf.c2[0] = -ry;
		xf.c1[1] = -rz;
		xf.c2[1] = rx;
		xf.c1[2] = ry;
		xf.c2[2] = -rx;
		xf.m     = ms;
		for (int a = 0; a < 3; a++) begin
			xf.d[a] = (dir_q == DIR_REVERSE) ? -DW'(off_q[a]) : DW'(off_q[a]);
		end
	end

	assign pt[0] = point.in_x;
	assign pt[1] = point.in_y;
	assign pt[2] = point.in_z;

	hdt_rot #(.FRAC_BITS(FRAC_BITS)) u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (point.valid),
		.in_ready  (point.ready),
		.in_p      (pt),
		.xf        (xf),
		.out_valid (rot_v),
		.out_ready (rot_r),
		.out_u     (u)
	);

	hdt_scl #(.FRAC_BITS(FRAC_BITS)) u_scl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rot_v),
		.in_ready  (rot_r),
		.in_u      (u),
		.xf        (xf),
		.out_valid (scl_v),
		.out_ready (scl_r),
		.out_r     (r)
	);

	hdt_sat #(.FRAC_BITS(FRAC_BITS)) u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (scl_v),
		.in_ready  (scl_r),
		.in_r      (r),
		.xf        (xf),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_c     (res_c),
		.out_ovf   (result.overflow)
	);

	assign result.out_x = res_c[0];
	assign result.out_y = res_c[1];
	assign result.out_z = res_c[2];

endmodule

`default_nettype wire

// ----- rtl/hdt_check.sv -----
// Port-level checks for the Helmert datum transform, bound to the top level.
// Depends on hdt_pkg and helmert_datum_transform.
`default_nettype none

module hdt_check (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_ready,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire hdt_pkg::coord_t out_x,
	input wire hdt_pkg::coord_t out_y,
	input wire hdt_pkg::coord_t out_z,
	input wire logic            overflow
);
	import hdt_pkg::*;

	localparam int             DEPTH = 6;
	localparam logic [3:0]     DEPTH_V = 4'(DEPTH);
	localparam logic [CW-1:0]  C_HI = {1'b0, {(CW - 1){1'b1}}};
	localparam logic [CW-1:0]  C_LO = {1'b1, {(CW - 1){1'b0}}};

	logic       take_in, take_out;
	logic [3:0] cnt_q;

	assign take_in  = in_valid && in_ready;
	assign take_out = out_valid && out_ready;

	// Requests taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
		end else begin
			case ({take_in, take_out})
				2'b10:   cnt_q <= cnt_q + 4'd1;
				2'b01:   cnt_q <= cnt_q - 4'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before it was taken");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z)
			&& $stable(overflow))
		else $error("stalled result changed");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 4'd0)
		else $error("result without an outstanding request");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_V)
		else $error("more requests in flight than pipeline stages");

	a_ovf_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> out_x == C_HI || out_x == C_LO || out_y == C_HI
			|| out_y == C_LO || out_z == C_HI || out_z == C_LO)
		else $error("overflow flagged with no coordinate at a limit");

endmodule

bind helmert_datum_transform hdt_check u_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (point.valid),
	.in_ready  (point.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_x     (result.out_x),
	.out_y     (result.out_y),
	.out_z     (result.out_z),
	.overflow  (result.overflow)
);

`default_nettype wire
